// ----- hdl/first_fit_coalescing_allocator_top_macros.svh -----
// Assertion macros used by the allocator controller.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ffca_pkg.sv -----
// Types, constants and codes shared by the allocator modules.
package ffca_pkg;

  localparam int ArenaBytes = 65536;
  localparam int HdrBytes   = 16;
  localparam int SplitMin   = HdrBytes * 2;
  localparam int Granules   = ArenaBytes / 8;
  localparam int IDX_W      = $clog2(Granules);
  localparam int TailIdx    = (ArenaBytes - HdrBytes) / 8;
  localparam int SIZE_W     = 17;
  localparam int NEED_W     = SIZE_W + 1;
  localparam int OFF_W      = 16;
  localparam int CNT_W      = 13;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_STATS = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISPATCH,
    S_AWALK,
    S_ANB,
    S_ALINK,
    S_AUSE,
    S_FG,
    S_FWALK,
    S_FWG,
    S_FLINK,
    S_SWALK
  } state_e;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_NEXT,
    RD_G
  } rd_src_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_NB,
    WR_LINK,
    WR_USE,
    WR_G
  } wr_sel_e;

  typedef struct packed {
    logic              mark;
    logic              has_next;
    logic [IDX_W-1:0]  next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic    load;
    rd_src_e rd_src;
    wr_sel_e wr_sel;
    logic    walk_step;
    logic    latch_cur;
    logic    ld_g;
    logic    acc;
    logic    finish;
    logic    ok;
    logic    res_off;
    logic    res_stats;
  } ffca_ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic clr_last;
    logic fits;
    logic has_next;
    logic mark;
    logic cur_lt_g;
    logic off_bad;
  } ffca_sts_t;

endpackage

// ----- hdl/ffca_datapath.sv -----
// Datapath: header store, list walk registers, arithmetic and result registers.
module ffca_datapath
  import ffca_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffca_ctl_t          ctl_i,
  output ffca_sts_t          sts_o,
  input  logic [1:0]         cmd_i,
  input  logic [SIZE_W-1:0]  req_size_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [OFF_W-1:0]   offset_o,
  output logic [SIZE_W-1:0]  remain_bytes_o,
  output logic [SIZE_W-1:0]  free_bytes_o,
  output logic [SIZE_W-1:0]  largest_free_o,
  output logic [CNT_W-1:0]   free_count_o
);

  localparam logic [IDX_W-1:0]  TAIL  = IDX_W'(TailIdx);
  localparam logic [SIZE_W-1:0] TSIZE = SIZE_W'(TailIdx * 8);

  hdr_t mem [Granules];
  hdr_t rdata_q;

  cmd_e              cmd_q;
  logic [NEED_W-1:0] need_q;
  logic [OFF_W-1:0]  off_q;
  logic [IDX_W-1:0]  g_q;
  logic [IDX_W-1:0]  head_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  prev_q;
  logic              prev_vld_q;
  hdr_t              prev_word_q;
  hdr_t              cur_word_q;
  logic [SIZE_W-1:0] gsize_q;
  logic [IDX_W-1:0]  gnext_q;
  logic              ghas_q;
  logic [SIZE_W-1:0] remaining_q, remaining_d;
  logic [IDX_W-1:0]  clr_q;
  logic [SIZE_W-1:0] fsum_q, fsum_d;
  logic [SIZE_W-1:0] fmax_q, fmax_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic              done_q;
  logic              ok_q;
  logic [OFF_W-1:0]  offset_q;
  logic [SIZE_W-1:0] fsum_out_q, fmax_out_q;
  logic [CNT_W-1:0]  fcnt_out_q;

  logic [NEED_W-1:0] need_raw;
  logic [NEED_W-1:0] need_new;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  hdr_t              wr_word;
  logic [NEED_W-1:0] spare;
  logic              split;
  logic [IDX_W-1:0]  nb;
  logic [IDX_W-1:0]  link;
  logic [SIZE_W-1:0] use_size;
  logic [IDX_W:0]    g_end;
  logic [IDX_W:0]    prev_end;
  logic              merge_next;
  logic              merge_prev;
  hdr_t              g_new;
  logic [IDX_W-1:0]  g_in;

  assign need_raw = NEED_W'(req_size_i) + NEED_W'(HdrBytes);
  assign need_new = (need_raw + NEED_W'(7)) & ~NEED_W'(7);
  assign g_in     = IDX_W'(free_offset_i[OFF_W-1:3] - IDX_W'(HdrBytes / 8));

  assign spare    = NEED_W'(cur_word_q.size) - need_q;
  assign split    = spare > NEED_W'(SplitMin);
  assign nb       = cur_q + IDX_W'(need_q >> 3);
  assign link     = split ? nb : cur_word_q.next;
  assign use_size = split ? SIZE_W'(need_q) : cur_word_q.size;

  assign g_end      = {1'b0, g_q} + (IDX_W+1)'(gsize_q >> 3);
  assign merge_next = (g_end == {1'b0, cur_q}) && (cur_q != TAIL);
  assign prev_end   = {1'b0, prev_q} + (IDX_W+1)'(prev_word_q.size >> 3);
  assign merge_prev = prev_vld_q && (prev_end == {1'b0, g_q});

  always_comb begin
    g_new.mark = 1'b0;
    if (merge_next) begin
      g_new.size     = gsize_q + rdata_q.size;
      g_new.next     = rdata_q.next;
      g_new.has_next = rdata_q.has_next;
    end else begin
      g_new.size     = gsize_q;
      g_new.next     = cur_q;
      g_new.has_next = 1'b1;
    end
  end

  always_comb begin
    case (ctl_i.rd_src)
      RD_CUR:  rd_addr = cur_q;
      RD_NEXT: rd_addr = rdata_q.next;
      RD_G:    rd_addr = g_q;
      default: rd_addr = cur_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_word = '0;
    case (ctl_i.wr_sel)
      WR_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == '0) begin
          wr_word = '{mark: 1'b0, has_next: 1'b1, next: TAIL, size: TSIZE};
        end
      end
      WR_NB: begin
        wr_en   = split;
        wr_addr = nb;
        wr_word = '{mark: 1'b0, has_next: 1'b1, next: cur_word_q.next,
                    size: SIZE_W'(spare)};
      end
      WR_LINK: begin
        wr_en   = prev_vld_q;
        wr_addr = prev_q;
        if (cmd_q == CMD_ALLOC) begin
          wr_word = '{mark: 1'b0, has_next: 1'b1, next: link, size: prev_word_q.size};
        end else if (merge_prev) begin
          wr_word = '{mark: 1'b0, has_next: ghas_q, next: gnext_q,
                      size: prev_word_q.size + gsize_q};
        end else begin
          wr_word = '{mark: 1'b0, has_next: 1'b1, next: g_q, size: prev_word_q.size};
        end
      end
      WR_USE: begin
        wr_en   = 1'b1;
        wr_addr = cur_q;
        wr_word = '{mark: 1'b1, has_next: 1'b0, next: '0, size: use_size};
      end
      WR_G: begin
        wr_en   = 1'b1;
        wr_addr = g_q;
        wr_word = g_new;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    remaining_d = remaining_q;
    if (ctl_i.ld_g) begin
      remaining_d = remaining_q + rdata_q.size;
    end else if (ctl_i.wr_sel == WR_USE) begin
      remaining_d = remaining_q - use_size;
    end
    fsum_d = fsum_q;
    fmax_d = fmax_q;
    fcnt_d = fcnt_q;
    if (ctl_i.acc) begin
      fsum_d = fsum_q + rdata_q.size;
      fmax_d = (rdata_q.size > fmax_q) ? rdata_q.size : fmax_q;
      fcnt_d = fcnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      remaining_q <= TSIZE;
      clr_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      done_q      <= ctl_i.finish;
      if (ctl_i.wr_sel == WR_CLR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (ctl_i.wr_sel == WR_LINK && !prev_vld_q) begin
        head_q <= (cmd_q == CMD_ALLOC) ? link : g_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= cmd_e'(cmd_i);
      need_q     <= need_new;
      off_q      <= free_offset_i;
      g_q        <= g_in;
      cur_q      <= head_q;
      prev_vld_q <= 1'b0;
      fsum_q     <= '0;
      fmax_q     <= '0;
      fcnt_q     <= '0;
    end else begin
      fsum_q <= fsum_d;
      fmax_q <= fmax_d;
      fcnt_q <= fcnt_d;
      if (ctl_i.walk_step) begin
        prev_q      <= cur_q;
        prev_word_q <= rdata_q;
        prev_vld_q  <= 1'b1;
        cur_q       <= rdata_q.next;
      end
    end
    if (ctl_i.latch_cur) begin
      cur_word_q <= rdata_q;
    end
    if (ctl_i.ld_g) begin
      gsize_q <= rdata_q.size;
    end
    if (ctl_i.wr_sel == WR_G) begin
      gsize_q <= g_new.size;
      gnext_q <= g_new.next;
      ghas_q  <= g_new.has_next;
    end
    if (ctl_i.finish) begin
      ok_q       <= ctl_i.ok;
      offset_q   <= ctl_i.res_off ? (OFF_W'({cur_q, 3'b000}) + OFF_W'(HdrBytes)) : '0;
      fsum_out_q <= ctl_i.res_stats ? fsum_d : '0;
      fmax_out_q <= ctl_i.res_stats ? fmax_d : '0;
      fcnt_out_q <= ctl_i.res_stats ? fcnt_d : '0;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.clr_last = (clr_q == IDX_W'(Granules - 1));
  assign sts_o.fits     = NEED_W'(rdata_q.size) >= need_q;
  assign sts_o.has_next = rdata_q.has_next;
  assign sts_o.mark     = rdata_q.mark;
  assign sts_o.cur_lt_g = cur_q < g_q;
  assign sts_o.off_bad  = (off_q < OFF_W'(HdrBytes)) || (off_q[2:0] != 3'b000) ||
                          (g_q >= TAIL);

  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign offset_o       = offset_q;
  assign remain_bytes_o = remaining_q;
  assign free_bytes_o   = fsum_out_q;
  assign largest_free_o = fmax_out_q;
  assign free_count_o   = fcnt_out_q;

endmodule

// ----- hdl/ffca_controller.sv -----
// Controller: state machine that sequences the clearing pass and each request.
module ffca_controller
  import ffca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ffca_sts_t sts_i,
  output ffca_ctl_t ctl_o
);

  `include "first_fit_coalescing_allocator_top_macros.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.rd_src = RD_CUR;
    ctl_o.wr_sel = WR_NONE;
    case (state_q)
      S_CLR: begin
        ctl_o.wr_sel = WR_CLR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_ALLOC: state_d = S_AWALK;
          CMD_STATS: state_d = S_SWALK;
          CMD_FREE: begin
            if (sts_i.off_bad) begin
              ctl_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else begin
              ctl_o.rd_src = RD_G;
              state_d      = S_FG;
            end
          end
          default: begin
            ctl_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_AWALK: begin
        if (sts_i.fits) begin
          ctl_o.latch_cur = 1'b1;
          state_d         = S_ANB;
        end else if (sts_i.has_next) begin
          ctl_o.walk_step = 1'b1;
          ctl_o.rd_src    = RD_NEXT;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ANB: begin
        ctl_o.wr_sel = WR_NB;
        state_d      = S_ALINK;
      end
      S_ALINK: begin
        ctl_o.wr_sel = WR_LINK;
        state_d      = S_AUSE;
      end
      S_AUSE: begin
        ctl_o.wr_sel  = WR_USE;
        ctl_o.finish  = 1'b1;
        ctl_o.ok      = 1'b1;
        ctl_o.res_off = 1'b1;
        state_d       = S_IDLE;
      end
      S_FG: begin
        if (sts_i.mark) begin
          ctl_o.ld_g = 1'b1;
          state_d    = S_FWALK;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FWALK: begin
        if (sts_i.cur_lt_g && sts_i.has_next) begin
          ctl_o.walk_step = 1'b1;
          ctl_o.rd_src    = RD_NEXT;
        end else begin
          ctl_o.latch_cur = 1'b1;
          state_d         = S_FWG;
        end
      end
      S_FWG: begin
        ctl_o.wr_sel = WR_G;
        state_d      = S_FLINK;
      end
      S_FLINK: begin
        ctl_o.wr_sel = WR_LINK;
        ctl_o.finish = 1'b1;
        ctl_o.ok     = 1'b1;
        state_d      = S_IDLE;
      end
      S_SWALK: begin
        ctl_o.acc = 1'b1;
        if (sts_i.has_next) begin
          ctl_o.walk_step = 1'b1;
          ctl_o.rd_src    = RD_NEXT;
        end else begin
          ctl_o.finish    = 1'b1;
          ctl_o.ok        = 1'b1;
          ctl_o.res_stats = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  `FFCA_ASSERT_NEXT(a_accept_dispatch, state_q == S_IDLE && start, state_q == S_DISPATCH, "accepted request did not reach dispatch")
  `FFCA_ASSERT_NEXT(a_finish_idle, ctl_o.finish, state_q == S_IDLE, "finished request did not return to idle")
  `FFCA_ASSERT_NOW(a_walk_no_write, state_q == S_AWALK || state_q == S_FWALK || state_q == S_SWALK, ctl_o.wr_sel == WR_NONE, "header store written during a list walk")
  `FFCA_ASSERT_NOW(a_ok_on_finish, ctl_o.ok || ctl_o.res_off || ctl_o.res_stats, ctl_o.finish, "result flags raised without a finish")

endmodule

// ----- hdl/first_fit_coalescing_allocator_top.sv -----
// An unknown request or a free with a bad offset ends at dispatch, a free of a block that is not
// live once its header is read, statistics or a failed allocate at the end of the free-list walk,
// allocate and free after the walk and their header writes; headers are read one per cycle.
// done_o rises the cycle after the last step; a new request is taken in that same cycle.
// After reset all 8192 header-store entries are cleared with busy high; the receiver cannot stall.
// Top level of the first-fit coalescing allocator.
module first_fit_coalescing_allocator_top
  import ffca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [SIZE_W-1:0] req_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [OFF_W-1:0]  offset_o,
  output logic [SIZE_W-1:0] remain_bytes_o,
  output logic [SIZE_W-1:0] free_bytes_o,
  output logic [SIZE_W-1:0] largest_free_o,
  output logic [CNT_W-1:0]  free_count_o
);

  ffca_ctl_t ctl;
  ffca_sts_t sts;

  ffca_controller u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .ctl_o (ctl)
  );

  ffca_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (cmd_i),
    .req_size_i    (req_size_i),
    .free_offset_i (free_offset_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .offset_o      (offset_o),
    .remain_bytes_o(remain_bytes_o),
    .free_bytes_o  (free_bytes_o),
    .largest_free_o(largest_free_o),
    .free_count_o  (free_count_o)
  );

endmodule
